// ----- hw/rtl/tshc_pkg.sv -----
// tshc_pkg: widths, constants and item types for the tilt stepper hold controller
// used by tshc_divider and tilt_stepper_hold_controller_unit; depends on nothing

package tshc_pkg;

    // potentiometer position width, 8 to 16
    localparam int POSITION_BITS = 10;

    // signed position error and loop sum widths
    localparam int ERR_W = POSITION_BITS + 1;
    localparam int PID_W = (ERR_W + 8 > 18) ? ERR_W + 8 : 18;

    // shared divider operand widths: angle numerator and period base
    localparam int DIVD_W = (POSITION_BITS + 7 > 16) ? POSITION_BITS + 7 : 16;
    localparam int DIVS_W = (POSITION_BITS > 17) ? POSITION_BITS : 17;
    localparam int CNT_W  = $clog2(DIVD_W + 1);

    localparam logic [15:0] PERIOD_BASE   = 16'd52400;
    localparam logic [13:0] DECAY_Q14     = 14'd14746;
    localparam logic [8:0]  ANGLE_OFFSET  = 9'd5;
    localparam logic [8:0]  ANGLE_MAX     = 9'd511;

    // pulse base over 100 as ceil(2^26/100) then a shift by 26, exact below 2^20
    localparam logic [19:0] PULSE_RECIP   = 20'd671089;
    localparam int          PULSE_SHIFT   = 26;

    // register reset values
    localparam logic [POSITION_BITS-1:0] LOWER_RESET = POSITION_BITS'(490);
    localparam logic [POSITION_BITS-1:0] UPPER_RESET = POSITION_BITS'(780);
    localparam logic [7:0]  DEADBAND_RESET = 8'd2;
    localparam logic [15:0] CAP_RESET      = 16'd1000;
    localparam logic [6:0]  DUTY_RESET     = 7'd40;

    // register indexes
    typedef logic [2:0] t_cfg_index;
    localparam t_cfg_index CFG_LOWER_LIMIT   = 3'd0;
    localparam t_cfg_index CFG_UPPER_LIMIT   = 3'd1;
    localparam t_cfg_index CFG_HOLD_DEADBAND = 3'd2;
    localparam t_cfg_index CFG_SPEED_CAP     = 3'd3;
    localparam t_cfg_index CFG_DUTY_PERCENT  = 3'd4;

    typedef struct packed {
        logic signed [15:0]        tilt_command;
        logic                      link_timeout;
        logic [POSITION_BITS-1:0]  position;
    } t_in_item;

    typedef struct packed {
        logic        direction;
        logic        driver_disable;
        logic        timer_enable;
        logic [15:0] period_count;
        logic [19:0] compare_value;
        logic [19:0] reload_value;
        logic [8:0]  tilt_angle;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- hw/rtl/tshc_divider.sv -----
// tshc_divider: restoring unsigned divider, one quotient bit per cycle
// depends on tshc_pkg for operand widths and request/response types

module tshc_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tshc_pkg::t_div_req  i_req,
    output tshc_pkg::t_div_rsp  o_rsp
);

    logic [tshc_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_done;
    logic [tshc_pkg::DIVS_W-1:0] r_rem;
    logic [tshc_pkg::DIVS_W-1:0] r_dvs;
    logic [tshc_pkg::DIVD_W-1:0] r_quo;

    logic [tshc_pkg::DIVS_W:0] shifted;
    logic [tshc_pkg::DIVS_W:0] trial;
    logic                      ge;

    assign shifted = {r_rem, r_quo[tshc_pkg::DIVD_W-1]};
    assign trial   = shifted - {1'b0, r_dvs};
    // no borrow means the shifted remainder covers the divisor
    assign ge      = ~trial[tshc_pkg::DIVS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_cnt  <= tshc_pkg::CNT_W'(tshc_pkg::DIVD_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == tshc_pkg::CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? trial[tshc_pkg::DIVS_W-1:0] : shifted[tshc_pkg::DIVS_W-1:0];
            r_quo <= {r_quo[tshc_pkg::DIVD_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- hw/rtl/tilt_stepper_hold_controller_unit.sv -----
// tilt_stepper_hold_controller_unit: top level, tick sequencer, loop state and registers
// depends on tshc_pkg and tshc_divider
//
// usage
//   input channel (i_in_valid / o_in_ready) takes one item per control tick: tilt command,
//   link timeout flag and position. o_in_ready is high only while the sequencer is idle.
//   output channel (o_out_valid / i_out_ready) gives one result item per input item.
//   configuration channel (i_cfg_valid / o_cfg_ready) is always ready; write only when idle.
// arithmetic
//   the angle and the step period share one restoring divider with a DIVD_W-bit dividend
//   (17 at the default position width); the pulse base over 100 is a reciprocal multiply.
//   before the period division, entering hold runs nothing else, holding runs the leak and
//   loop steps and a nonzero command runs the angle division. each item goes to the output
//   register before the next input item is taken in.
// reset
//   synchronous active-low reset restores the register defaults, clears the loop state,
//   sets the hold target to the default lower limit and drops o_out_valid.
// stalls
//   a finished item waits in the output register; the next input item is accepted and
//   worked on meanwhile, and the sequencer holds at its last step until the slot is free.

module tilt_stepper_hold_controller_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input items
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  tshc_pkg::t_in_item     i_in_data,
    // result items
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output tshc_pkg::t_out_item    o_out_data,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  tshc_pkg::t_cfg_index   i_cfg_index,
    input  logic [15:0]            i_cfg_data
);

    localparam int PB = tshc_pkg::POSITION_BITS;
    localparam int EW = tshc_pkg::ERR_W;
    localparam int PW = tshc_pkg::PID_W;

    // sequencer steps
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_PREP      = 4'd1;
    localparam logic [3:0] S_ANGLE     = 4'd2;
    localparam logic [3:0] S_LEAK      = 4'd3;
    localparam logic [3:0] S_PID       = 4'd4;
    localparam logic [3:0] S_PER_START = 4'd5;
    localparam logic [3:0] S_PER       = 4'd6;
    localparam logic [3:0] S_QUOT      = 4'd7;
    localparam logic [3:0] S_MUL       = 4'd8;
    localparam logic [3:0] S_FIN       = 4'd9;

    // saturate a loop sum to signed 16 bit
    function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
        logic signed [15:0] res;
        if (v > PW'(32767))
            res = 16'sh7fff;
        else if (v < -(PW'(32768)))
            res = -16'sh8000;
        else
            res = v[15:0];
        return res;
    endfunction

    logic [3:0] r_state, n_state;

    // configuration registers
    logic [PB-1:0] r_lower, r_upper;
    logic [7:0]    r_deadband;
    logic [15:0]   r_cap;
    logic [6:0]    r_duty_pct;

    // loop state kept across ticks
    logic                 r_prev_nz;
    logic [PB-1:0]        r_hold_target;
    logic signed [EW-1:0] r_prev_err;
    logic signed [15:0]   r_leaky;
    logic [8:0]           r_angle;

    // per-item working registers
    logic signed [15:0]   r_cmd;
    logic [PB-1:0]        r_pos;
    logic signed [EW-1:0] r_err;
    logic signed [EW:0]   r_diff;
    logic [15:0]          r_dec;
    logic                 r_dec_neg;
    logic                 r_lim;
    logic [15:0]          r_speed;
    logic [6:0]           r_duty;
    logic                 r_dir, r_dis, r_timer;
    logic [15:0]          r_period;
    logic [13:0]          r_quo100;
    logic [20:0]          r_prod;

    logic                 r_out_valid;
    tshc_pkg::t_out_item  r_out;

    tshc_pkg::t_div_req   div_req;
    tshc_pkg::t_div_rsp   div_rsp;

    logic in_acc, out_free;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid & o_in_ready;
    assign out_free    = ~r_out_valid | i_out_ready;
    assign o_cfg_ready = 1'b1;

    // tick classification
    logic cmd_zero, enter_hold, run;
    assign cmd_zero   = (r_cmd == 16'sd0);
    assign enter_hold = r_prev_nz & cmd_zero;
    assign run        = ~cmd_zero;

    // position error against the hold target
    logic signed [EW-1:0] err_c;
    assign err_c = $signed({1'b0, r_pos}) - $signed({1'b0, r_hold_target});

    // leaky sum decay, magnitude times 0.9 in q14
    logic [15:0] leak_u, leak_mag;
    logic [29:0] dec_prod;
    assign leak_u   = r_leaky;
    assign leak_mag = leak_u[15] ? (16'd0 - leak_u) : leak_u;
    assign dec_prod = 30'(leak_mag) * 30'(tshc_pkg::DECAY_Q14);

    // end of travel limits
    logic lim_c;
    assign lim_c = ((r_pos > r_upper) & ~r_cmd[15]) | ((r_pos < r_lower) & r_cmd[15]);

    // angle numerator rel*82 and span
    logic [PB-1:0] rel, span;
    logic [PB+6:0] rel_x, ang_num;
    assign rel     = (r_pos > r_lower) ? (r_pos - r_lower) : '0;
    assign span    = (r_upper > r_lower) ? (r_upper - r_lower) : PB'(1);
    assign rel_x   = (PB + 7)'(rel);
    assign ang_num = (rel_x << 6) + (rel_x << 4) + (rel_x << 1);

    logic [15:0] cmd_u, cmd_mag;
    assign cmd_u   = r_cmd;
    assign cmd_mag = cmd_u[15] ? (16'd0 - cmd_u) : cmd_u;

    // leaky sum update
    logic signed [PW-1:0]  err_x, diff_x, leak_x, dec_x, leak_sum;
    logic signed [EW:0]    diff_c;
    logic signed [15:0]    leak_new;
    assign err_x    = {{(PW - EW){r_err[EW-1]}}, r_err};
    assign dec_x    = r_dec_neg ? -$signed(PW'(r_dec)) : $signed(PW'(r_dec));
    assign leak_sum = err_x + dec_x;
    assign leak_new = sat16(leak_sum);
    assign diff_c   = $signed({r_err[EW-1], r_err}) - $signed({r_prev_err[EW-1], r_prev_err});

    // position loop: 32*error + difference + leaky sum
    logic signed [PW-1:0] pid_sum;
    logic signed [15:0]   pid;
    logic [15:0]          pid_u, pid_mag, pid_speed;
    logic [EW-1:0]        err_u, err_mag;
    logic                 outside_band;
    assign diff_x    = {{(PW - EW - 1){r_diff[EW]}}, r_diff};
    assign leak_x    = {{(PW - 16){r_leaky[15]}}, r_leaky};
    assign pid_sum   = (err_x <<< 5) + diff_x + leak_x;
    assign pid       = sat16(pid_sum);
    assign pid_u     = pid;
    assign pid_mag   = pid_u[15] ? (16'd0 - pid_u) : pid_u;
    assign pid_speed = (pid_mag < r_cap) ? pid_mag : r_cap;
    assign err_u     = r_err;
    assign err_mag   = err_u[EW-1] ? (EW'(0) - err_u) : err_u;
    assign outside_band = (err_mag >= EW'(r_deadband));

    // period, pulse base and output words
    logic [16:0] per_div;
    logic [19:0] pulse_base, reload_c, cmp_c;
    logic [39:0] quot_prod;
    assign per_div    = 17'(r_lim ? 16'd0 : r_speed) + 17'd1;
    assign pulse_base = {r_period, 4'b0000} - 20'd10;
    assign reload_c   = {r_period, 4'b0000} - 20'd2;
    // pulse base over 100 by reciprocal multiply
    assign quot_prod  = 40'(pulse_base) * 40'(tshc_pkg::PULSE_RECIP);
    assign cmp_c      = (21'(pulse_base) >= r_prod) ? (pulse_base - r_prod[19:0]) : 20'd0;

    // shared divider requests
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = tshc_pkg::DIVD_W'(ang_num);
        div_req.divisor  = tshc_pkg::DIVS_W'(span);
        unique case (r_state)
            S_PREP: begin
                div_req.start = run;
            end
            S_PER_START: begin
                div_req.start    = 1'b1;
                div_req.dividend = tshc_pkg::DIVD_W'(tshc_pkg::PERIOD_BASE);
                div_req.divisor  = tshc_pkg::DIVS_W'(per_div);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    tshc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (in_acc) n_state = S_PREP;
            S_PREP: begin
                if (enter_hold)
                    n_state = S_PER_START;
                else if (run)
                    n_state = S_ANGLE;
                else
                    n_state = S_LEAK;
            end
            S_ANGLE:     if (div_rsp.done) n_state = S_PER_START;
            S_LEAK:      n_state = S_PID;
            S_PID:       n_state = S_PER_START;
            S_PER_START: n_state = S_PER;
            S_PER:       if (div_rsp.done) n_state = S_QUOT;
            S_QUOT:      n_state = S_MUL;
            S_MUL:       n_state = S_FIN;
            S_FIN:       if (out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // control, configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_lower       <= tshc_pkg::LOWER_RESET;
            r_upper       <= tshc_pkg::UPPER_RESET;
            r_deadband    <= tshc_pkg::DEADBAND_RESET;
            r_cap         <= tshc_pkg::CAP_RESET;
            r_duty_pct    <= tshc_pkg::DUTY_RESET;
            r_prev_nz     <= 1'b0;
            r_hold_target <= tshc_pkg::LOWER_RESET;
            r_prev_err    <= '0;
            r_leaky       <= '0;
            r_angle       <= '0;
        end else begin
            r_state <= n_state;

            if (r_state == S_FIN && out_free)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tshc_pkg::CFG_LOWER_LIMIT:   r_lower    <= i_cfg_data[PB-1:0];
                    tshc_pkg::CFG_UPPER_LIMIT:   r_upper    <= i_cfg_data[PB-1:0];
                    tshc_pkg::CFG_HOLD_DEADBAND: r_deadband <= i_cfg_data[7:0];
                    tshc_pkg::CFG_SPEED_CAP:     r_cap      <= i_cfg_data;
                    tshc_pkg::CFG_DUTY_PERCENT:  r_duty_pct <= i_cfg_data[6:0];
                    default: ;
                endcase
            end

            if (r_state == S_PREP) begin
                r_prev_nz <= run;
                if (enter_hold)
                    r_hold_target <= r_pos;
            end

            if (r_state == S_LEAK) begin
                r_prev_err <= r_err;
                r_leaky    <= leak_new;
            end

            // angle only moves on a nonzero command
            if (r_state == S_ANGLE && div_rsp.done) begin
                if (div_rsp.quotient >
                        tshc_pkg::DIVD_W'(tshc_pkg::ANGLE_MAX - tshc_pkg::ANGLE_OFFSET))
                    r_angle <= tshc_pkg::ANGLE_MAX;
                else
                    r_angle <= div_rsp.quotient[8:0] + tshc_pkg::ANGLE_OFFSET;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_in_data.link_timeout ? 16'sd0 : i_in_data.tilt_command;
            r_pos <= i_in_data.position;
        end

        unique case (r_state)
            S_PREP: begin
                r_err     <= err_c;
                r_dec     <= dec_prod[29:14];
                r_dec_neg <= leak_u[15];
                r_lim     <= lim_c;
                if (enter_hold) begin
                    r_speed <= 16'd0;
                    r_duty  <= 7'd0;
                    r_dir   <= 1'b1;
                    r_dis   <= 1'b1;
                    r_timer <= 1'b0;
                end else if (run) begin
                    r_speed <= cmd_mag;
                    r_duty  <= r_duty_pct;
                    r_dir   <= ~r_cmd[15];
                    r_dis   <= 1'b0;
                    r_timer <= 1'b1;
                end
            end
            S_LEAK: begin
                r_diff <= diff_c;
            end
            S_PID: begin
                r_speed <= pid_speed;
                r_dir   <= pid[15];
                r_dis   <= 1'b0;
                r_timer <= outside_band;
                r_duty  <= outside_band ? r_duty_pct : 7'd0;
            end
            S_PER: begin
                if (div_rsp.done)
                    r_period <= div_rsp.quotient[15:0];
            end
            S_QUOT: begin
                r_quo100 <= quot_prod[tshc_pkg::PULSE_SHIFT +: 14];
            end
            S_MUL: begin
                r_prod <= 21'(r_duty) * 21'(r_quo100);
            end
            S_FIN: begin
                if (out_free) begin
                    r_out.direction      <= r_dir;
                    r_out.driver_disable <= r_dis;
                    r_out.timer_enable   <= r_timer;
                    r_out.period_count   <= r_period;
                    r_out.compare_value  <= cmp_c;
                    r_out.reload_value   <= reload_c;
                    r_out.tilt_angle     <= r_angle;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result item raised outside the final step");

    a_period_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.period_count != 16'd0)
        else $error("zero step period");

    a_reload_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.reload_value == ({o_out_data.period_count, 4'b0000} - 20'd2))
        else $error("reload word does not follow the period");

    a_disable_no_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.driver_disable |-> !o_out_data.timer_enable)
        else $error("timer running while driver disabled");
`endif

endmodule
